// ----- rtl/crsc_pkg.sv -----
package crsc_pkg;

   localparam int WORD_W         = 64;
   localparam int INDEX_W        = 5;
   localparam int OPCODE_W       = 2;
   localparam int POS_W          = 2;
   localparam int LANES          = 4;
   localparam int STEP_W         = 4;
   localparam int ROUND_COUNT    = 4;
   localparam int CONSTANT_DEPTH = 32;
   localparam int REQ_DATA_W     = 72;
   localparam int RSP_DATA_W     = 72;
   localparam int CSR_INDEX_W    = 3;

   localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_DATA  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_0 = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_1 = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_2 = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_3 = 3'd7;

   // rotation amounts and table offsets share one list:
   // state words use entries 0..3, key words entries 4..7
   localparam int MIX_CONST [8] = '{3, 5, 7, 13, 17, 19, 23, 29};

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FINAL,
      ST_OUT
   } crsc_state_type;

   typedef struct packed {
      logic       mix_en;
      logic [2:0] sel;
   } crsc_mix_ctrl_type;

endpackage

// ----- rtl/crsc_const_ram.sv -----
module crsc_const_ram #(
   parameter int DEPTH = crsc_pkg::CONSTANT_DEPTH,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                        clock,
   input  logic                        we,
   input  logic [AW-1:0]               waddr,
   input  logic [crsc_pkg::WORD_W-1:0] wdata,
   input  logic [AW-1:0]               raddr,
   output logic [crsc_pkg::WORD_W-1:0] rdata
);

   logic [crsc_pkg::WORD_W-1:0] const_mem_ff [DEPTH];
   logic [crsc_pkg::WORD_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         const_mem_ff[waddr] <= wdata;
      end
      rdata_ff <= const_mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/crsc_mix_unit.sv -----
module crsc_mix_unit (
   input  logic [crsc_pkg::WORD_W-1:0]  target,
   input  logic [crsc_pkg::WORD_W-1:0]  op_a,
   input  logic [crsc_pkg::WORD_W-1:0]  op_b,
   input  logic [crsc_pkg::WORD_W-1:0]  op_c,
   input  logic [crsc_pkg::WORD_W-1:0]  addend,
   input  crsc_pkg::crsc_mix_ctrl_type  ctrl,
   output logic [crsc_pkg::WORD_W-1:0]  result
);

   function automatic logic [crsc_pkg::WORD_W-1:0] rotl(
      input logic [crsc_pkg::WORD_W-1:0] x,
      input int                          n
   );
      return (x << n) | (x >> (crsc_pkg::WORD_W - n));
   endfunction

   logic [crsc_pkg::WORD_W-1:0] choice;
   logic [crsc_pkg::WORD_W-1:0] rotated;

   assign choice = op_c ^ (op_a & (op_b ^ op_c));

   always_comb begin
      case (ctrl.sel)
         3'd0:    rotated = rotl(choice, crsc_pkg::MIX_CONST[0]);
         3'd1:    rotated = rotl(choice, crsc_pkg::MIX_CONST[1]);
         3'd2:    rotated = rotl(choice, crsc_pkg::MIX_CONST[2]);
         3'd3:    rotated = rotl(choice, crsc_pkg::MIX_CONST[3]);
         3'd4:    rotated = rotl(choice, crsc_pkg::MIX_CONST[4]);
         3'd5:    rotated = rotl(choice, crsc_pkg::MIX_CONST[5]);
         3'd6:    rotated = rotl(choice, crsc_pkg::MIX_CONST[6]);
         3'd7:    rotated = rotl(choice, crsc_pkg::MIX_CONST[7]);
         default: rotated = choice;
      endcase
   end

   assign result = target ^ (ctrl.mix_en ? rotated : addend);

endmodule

// ----- rtl/choice_rotate_stream_cipher_top.sv -----
// Keystream cipher over 64-bit words. A load transfer writes one round
// constant, a start transfer reloads state and key from the csr registers,
// and a data transfer returns the text word XORed with the next keystream
// word. Data words at positions one to three go straight to output; the
// word at position zero first runs a block of ROUND_COUNT rounds and a
// final key mix. A block runs on one shared choice/rotate unit that updates
// one state or key word per cycle, sixteen updates a round, fed by the
// single read port of the constant RAM. The block is not ready while a
// block runs or while a result waits for its output slot.
// Every table entry a block reads must have been loaded since reset.
module choice_rotate_stream_cipher_top #(
   parameter int ROUND_COUNT    = crsc_pkg::ROUND_COUNT,
   parameter int CONSTANT_DEPTH = crsc_pkg::CONSTANT_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // opcode[1:0], table_index[6:2], word_value[70:7], zero[71]
   input  logic [crsc_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // text_word[63:0], word_position[65:64], zero[71:66]
   output logic [crsc_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                             csr_we,
   input  logic [crsc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [crsc_pkg::WORD_W-1:0]      csr_wdata
);

   localparam int RW = (ROUND_COUNT > 1) ? $clog2(ROUND_COUNT) : 1;
   localparam int AW = $clog2(CONSTANT_DEPTH);
   localparam logic [RW-1:0] ROUND_LAST = RW'(ROUND_COUNT - 1);
   localparam logic [crsc_pkg::STEP_W-1:0] STEP_LAST = '1;

   logic [crsc_pkg::OPCODE_W-1:0] req_opcode;
   logic [crsc_pkg::INDEX_W-1:0]  req_index;
   logic [crsc_pkg::WORD_W-1:0]   req_word;

   assign req_opcode = req_tdata[1:0];
   assign req_index  = req_tdata[6:2];
   assign req_word   = req_tdata[70:7];

   logic [crsc_pkg::WORD_W-1:0] key_reg_ff   [crsc_pkg::LANES];
   logic [crsc_pkg::WORD_W-1:0] nonce_reg_ff [crsc_pkg::LANES];
   logic [crsc_pkg::WORD_W-1:0] state_word_ff [crsc_pkg::LANES];
   logic [crsc_pkg::WORD_W-1:0] key_word_ff   [crsc_pkg::LANES];

   crsc_pkg::crsc_state_type       state_ff, state_in;
   logic [crsc_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [RW-1:0]                  round_ff, round_in;
   logic [crsc_pkg::POS_W-1:0]     cnt_ff, cnt_in;
   logic [crsc_pkg::WORD_W-1:0]    word_ff;
   logic                           rsp_valid_ff;
   logic [crsc_pkg::WORD_W-1:0]    rsp_text_ff;
   logic [crsc_pkg::POS_W-1:0]     rsp_pos_ff;

   logic ram_we;
   logic start_load;
   logic word_take;
   logic unit_we;
   logic final_mix;
   logic load_rsp;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      round_in   = round_ff;
      cnt_in     = cnt_ff;
      req_tready = (state_ff == crsc_pkg::ST_IDLE);
      ram_we     = 1'b0;
      start_load = 1'b0;
      word_take  = 1'b0;
      unit_we    = 1'b0;
      final_mix  = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         crsc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               case (req_opcode)
                  crsc_pkg::OP_LOAD: begin
                     ram_we = 1'b1;
                  end
                  crsc_pkg::OP_START: begin
                     start_load = 1'b1;
                     cnt_in     = '0;
                  end
                  crsc_pkg::OP_DATA: begin
                     word_take = 1'b1;
                     state_in  = (cnt_ff == '0) ? crsc_pkg::ST_ROUND : crsc_pkg::ST_OUT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         crsc_pkg::ST_ROUND: begin
            unit_we = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               if (round_ff == ROUND_LAST) begin
                  round_in = '0;
                  state_in = crsc_pkg::ST_FINAL;
               end else begin
                  round_in = round_ff + 1'b1;
               end
            end
         end
         crsc_pkg::ST_FINAL: begin
            final_mix = 1'b1;
            state_in  = crsc_pkg::ST_OUT;
         end
         crsc_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = crsc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = crsc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= crsc_pkg::ST_IDLE;
         step_ff      <= '0;
         round_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         round_ff <= round_in;
         cnt_ff   <= cnt_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (word_take) begin
         word_ff <= req_word;
      end
      if (load_rsp) begin
         rsp_text_ff <= word_ff ^ state_word_ff[cnt_ff];
         rsp_pos_ff  <= cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < crsc_pkg::LANES; i++) begin
            key_reg_ff[i]   <= '0;
            nonce_reg_ff[i] <= '0;
         end
      end else if (csr_we) begin
         case (csr_index)
            crsc_pkg::CSR_KEY_0:   key_reg_ff[0]   <= csr_wdata;
            crsc_pkg::CSR_KEY_1:   key_reg_ff[1]   <= csr_wdata;
            crsc_pkg::CSR_KEY_2:   key_reg_ff[2]   <= csr_wdata;
            crsc_pkg::CSR_KEY_3:   key_reg_ff[3]   <= csr_wdata;
            crsc_pkg::CSR_NONCE_0: nonce_reg_ff[0] <= csr_wdata;
            crsc_pkg::CSR_NONCE_1: nonce_reg_ff[1] <= csr_wdata;
            crsc_pkg::CSR_NONCE_2: nonce_reg_ff[2] <= csr_wdata;
            crsc_pkg::CSR_NONCE_3: nonce_reg_ff[3] <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // fetch the constant for the step that runs next cycle
   logic [crsc_pkg::INDEX_W-1:0] rd_index;
   logic [crsc_pkg::WORD_W-1:0]  const_q;

   assign rd_index = crsc_pkg::INDEX_W'(round_in)
                   ^ crsc_pkg::INDEX_W'(crsc_pkg::MIX_CONST[{step_in[3], step_in[1:0]}]);

   crsc_const_ram #(
      .DEPTH (CONSTANT_DEPTH),
      .AW    (AW)
   ) u_const_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (req_index[AW-1:0]),
      .wdata (req_word),
      .raddr (rd_index[AW-1:0]),
      .rdata (const_q)
   );

   logic [1:0]                   lane;
   logic [1:0]                   phase;
   logic [crsc_pkg::WORD_W-1:0]  bank [crsc_pkg::LANES];
   logic [crsc_pkg::WORD_W-1:0]  unit_addend;
   logic [crsc_pkg::WORD_W-1:0]  unit_result;
   crsc_pkg::crsc_mix_ctrl_type  unit_ctrl;

   assign lane  = step_ff[1:0];
   assign phase = step_ff[3:2];

   always_comb begin
      for (int i = 0; i < crsc_pkg::LANES; i++) begin
         bank[i] = phase[1] ? key_word_ff[i] : state_word_ff[i];
      end
   end

   assign unit_addend   = phase[1] ? const_q : (key_word_ff[lane] ^ const_q);
   assign unit_ctrl.mix_en = phase[0];
   assign unit_ctrl.sel    = {phase[1], lane};

   crsc_mix_unit u_mix_unit (
      .target (bank[lane]),
      .op_a   (bank[lane + 2'd1]),
      .op_b   (bank[lane + 2'd2]),
      .op_c   (bank[lane + 2'd3]),
      .addend (unit_addend),
      .ctrl   (unit_ctrl),
      .result (unit_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < crsc_pkg::LANES; i++) begin
            state_word_ff[i] <= '0;
            key_word_ff[i]   <= '0;
         end
      end else if (start_load) begin
         for (int i = 0; i < crsc_pkg::LANES; i++) begin
            state_word_ff[i] <= nonce_reg_ff[i];
            key_word_ff[i]   <= key_reg_ff[i];
         end
      end else if (unit_we) begin
         if (phase[1]) begin
            key_word_ff[lane] <= unit_result;
         end else begin
            state_word_ff[lane] <= unit_result;
         end
      end else if (final_mix) begin
         for (int i = 0; i < crsc_pkg::LANES; i++) begin
            state_word_ff[i] <= state_word_ff[i] ^ key_word_ff[i];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_pos_ff, rsp_text_ff};

   a_idle_counters: assert property (@(posedge clock) disable iff (reset)
      (state_ff != crsc_pkg::ST_ROUND) |-> (step_ff == '0 && round_ff == '0))
      else $error("round counters not cleared outside a block");

   a_short_word: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_opcode == crsc_pkg::OP_DATA && cnt_ff != '0)
      |=> (state_ff == crsc_pkg::ST_OUT))
      else $error("data word off block start did not go to output");

   a_final_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == crsc_pkg::ST_FINAL) |=> (state_ff == crsc_pkg::ST_OUT))
      else $error("final key mix not followed by output");

   a_rsp_pos: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_tvalid && rsp_tdata[65:64] == $past(cnt_ff)
                    && cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("result position does not track word count");

endmodule

// ----- test/choice_rotate_stream_cipher_top_tb.sv -----
module choice_rotate_stream_cipher_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [crsc_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 16 * crsc_pkg::ROUND_COUNT + 16;
   localparam int unsigned LIMIT_CYCLES = 1_000_000;
   localparam int PRINT_CAP = 40;

   typedef struct packed {
      logic [crsc_pkg::WORD_W-1:0] text;
      logic [crsc_pkg::POS_W-1:0]  pos;
   } cipher_word_type;

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [crsc_pkg::REQ_DATA_W-1:0]   req_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [crsc_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_we;
   logic [crsc_pkg::CSR_INDEX_W-1:0]  csr_index;
   logic [crsc_pkg::WORD_W-1:0]       csr_wdata;

   logic [crsc_pkg::WORD_W-1:0] key_csr     [crsc_pkg::LANES];
   logic [crsc_pkg::WORD_W-1:0] nonce_csr   [crsc_pkg::LANES];
   logic [crsc_pkg::WORD_W-1:0] ks_state    [crsc_pkg::LANES];
   logic [crsc_pkg::WORD_W-1:0] ks_key      [crsc_pkg::LANES];
   logic [crsc_pkg::WORD_W-1:0] const_table [crsc_pkg::CONSTANT_DEPTH];
   logic [crsc_pkg::POS_W-1:0]  word_pos;
   cipher_word_type             pending_words [$];

   int gap_max   = 3;
   int burst_max = 8;
   int ready_max = 8;
   int stall_max = 4;
   int burst_left = 0;
   int hold_len  = 0;

   int mismatches = 0;
   int n_words    = 0;
   int n_starts   = 0;
   int n_loads    = 0;
   int n_ignored  = 0;
   int n_checked  = 0;
   int n_settings = 0;
   int unsigned cycle_count = 0;

   choice_rotate_stream_cipher_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin : watchdog
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("simulation failed");
      $finish;
   end

   function automatic logic [crsc_pkg::WORD_W-1:0] chrot(
      input logic [crsc_pkg::WORD_W-1:0] a, b, c,
      input int n);
      logic [crsc_pkg::WORD_W-1:0] v;
      v = c ^ (a & (b ^ c));
      return (v << n) | (v >> (crsc_pkg::WORD_W - n));
   endfunction

   function automatic logic [crsc_pkg::WORD_W-1:0] tab(input int r, input int off);
      return const_table[(r ^ off) % crsc_pkg::CONSTANT_DEPTH];
   endfunction

   function automatic void advance_keystream();
      for (int r = 0; r < crsc_pkg::ROUND_COUNT; r++) begin
         ks_state[0] ^= ks_key[0] ^ tab(r, 3);
         ks_state[1] ^= ks_key[1] ^ tab(r, 5);
         ks_state[2] ^= ks_key[2] ^ tab(r, 7);
         ks_state[3] ^= ks_key[3] ^ tab(r, 13);
         ks_state[0] ^= chrot(ks_state[1], ks_state[2], ks_state[3], 3);
         ks_state[1] ^= chrot(ks_state[2], ks_state[3], ks_state[0], 5);
         ks_state[2] ^= chrot(ks_state[3], ks_state[0], ks_state[1], 7);
         ks_state[3] ^= chrot(ks_state[0], ks_state[1], ks_state[2], 13);
         ks_key[0] ^= tab(r, 17);
         ks_key[1] ^= tab(r, 19);
         ks_key[2] ^= tab(r, 23);
         ks_key[3] ^= tab(r, 29);
         ks_key[0] ^= chrot(ks_key[1], ks_key[2], ks_key[3], 17);
         ks_key[1] ^= chrot(ks_key[2], ks_key[3], ks_key[0], 19);
         ks_key[2] ^= chrot(ks_key[3], ks_key[0], ks_key[1], 23);
         ks_key[3] ^= chrot(ks_key[0], ks_key[1], ks_key[2], 29);
      end
      for (int i = 0; i < crsc_pkg::LANES; i++) ks_state[i] ^= ks_key[i];
   endfunction

   function automatic void predict_transfer(input logic [crsc_pkg::OPCODE_W-1:0] op,
                                            input logic [crsc_pkg::INDEX_W-1:0]  idx,
                                            input logic [crsc_pkg::WORD_W-1:0]   w);
      cipher_word_type next_word;
      case (op)
         crsc_pkg::OP_LOAD: begin
            const_table[idx] = w;
            n_loads++;
         end
         crsc_pkg::OP_START: begin
            for (int i = 0; i < crsc_pkg::LANES; i++) begin
               ks_state[i] = nonce_csr[i];
               ks_key[i]   = key_csr[i];
            end
            word_pos = '0;
            n_starts++;
         end
         crsc_pkg::OP_DATA: begin
            if (word_pos == '0) advance_keystream();
            next_word.text = w ^ ks_state[word_pos];
            next_word.pos  = word_pos;
            pending_words.push_back(next_word);
            word_pos = word_pos + 1'b1;
            n_words++;
         end
         default: n_ignored++;
      endcase
   endfunction

   function automatic logic [crsc_pkg::WORD_W-1:0] rand_word();
      case ($urandom_range(9, 0))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [crsc_pkg::WORD_W-1:0] got,
                                  input logic [crsc_pkg::WORD_W-1:0] want);
      if (mismatches < PRINT_CAP)
         $display("[%0t] mismatch %s: got %h want %h", $realtime, what, got, want);
      mismatches++;
   endtask

   task automatic send_transfer(input logic [crsc_pkg::OPCODE_W-1:0] op,
                                input logic [crsc_pkg::INDEX_W-1:0]  idx,
                                input logic [crsc_pkg::WORD_W-1:0]   w);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(gap_max, 0);
         burst_left = $urandom_range(burst_max, 1);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, w, idx, op};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_transfer(op, idx, w);
   endtask

   // hold until every result is back and the block has had time to finish
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic load_registers(input logic [crsc_pkg::WORD_W-1:0] vals [8]);
      logic [crsc_pkg::CSR_INDEX_W-1:0] idx;
      for (int i = 0; i < 8; i++) begin
         idx = crsc_pkg::CSR_KEY_0 + crsc_pkg::CSR_INDEX_W'(i);
         csr_we    <= 1'b1;
         csr_index <= idx;
         csr_wdata <= vals[i];
         if (idx < crsc_pkg::CSR_NONCE_0)
            key_csr[idx - crsc_pkg::CSR_KEY_0] = vals[i];
         else
            nonce_csr[idx - crsc_pkg::CSR_NONCE_0] = vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      n_settings++;
   endtask

   task automatic load_random_registers();
      logic [crsc_pkg::WORD_W-1:0] vals [8];
      for (int i = 0; i < 8; i++) vals[i] = {$urandom, $urandom};
      load_registers(vals);
   endtask

   task automatic test_table_fill();
      logic [crsc_pkg::WORD_W-1:0] w;
      for (int i = 0; i < crsc_pkg::CONSTANT_DEPTH; i++) begin
         w = (i == 0) ? '0 : (i == crsc_pkg::CONSTANT_DEPTH - 1) ? '1 : {$urandom, $urandom};
         send_transfer(crsc_pkg::OP_LOAD, crsc_pkg::INDEX_W'(i), w);
      end
   endtask

   task automatic test_data_before_start();
      send_transfer(crsc_pkg::OP_DATA, '0, '0);
      send_transfer(crsc_pkg::OP_DATA, '1, '1);
      for (int i = 0; i < 3; i++)
         send_transfer(crsc_pkg::OP_DATA, crsc_pkg::INDEX_W'($urandom), rand_word());
   endtask

   task automatic test_start_and_wrap();
      wait_idle();
      load_random_registers();
      send_transfer(crsc_pkg::OP_START, '0, '1);
      for (int i = 0; i < 5; i++)
         send_transfer(crsc_pkg::OP_DATA, crsc_pkg::INDEX_W'($urandom), rand_word());
   endtask

   task automatic test_csr_after_start();
      send_transfer(crsc_pkg::OP_START, '1, '0);
      wait_idle();
      load_random_registers();
      send_transfer(crsc_pkg::OP_DATA, '0, {$urandom, $urandom});
      send_transfer(crsc_pkg::OP_DATA, '0, {$urandom, $urandom});
      send_transfer(crsc_pkg::OP_START, '0, '0);
      send_transfer(crsc_pkg::OP_DATA, '0, {$urandom, $urandom});
   endtask

   task automatic test_restart_mid_block();
      send_transfer(crsc_pkg::OP_DATA, '0, {$urandom, $urandom});
      send_transfer(crsc_pkg::OP_START, '0, '0);
      send_transfer(crsc_pkg::OP_DATA, '0, {$urandom, $urandom});
   endtask

   task automatic test_unused_opcode();
      send_transfer(OP_UNUSED, '1, '1);
      send_transfer(crsc_pkg::OP_DATA, '0, {$urandom, $urandom});
      send_transfer(OP_UNUSED, '0, {$urandom, $urandom});
      send_transfer(crsc_pkg::OP_DATA, '0, {$urandom, $urandom});
   endtask

   task automatic test_table_reload();
      send_transfer(crsc_pkg::OP_LOAD, 5'd3, {$urandom, $urandom});
      send_transfer(crsc_pkg::OP_LOAD, 5'd28, {$urandom, $urandom});
      for (int i = 0; i < 4; i++) send_transfer(crsc_pkg::OP_DATA, '0, rand_word());
   endtask

   // receiver holds off while the sender keeps offering a dense stream
   task automatic test_backpressure();
      int saved_gap;
      saved_gap = gap_max;
      gap_max = 0;
      hold_len = 400;
      send_transfer(crsc_pkg::OP_START, '0, '0);
      for (int i = 0; i < 40; i++) send_transfer(crsc_pkg::OP_DATA, '0, rand_word());
      gap_max = saved_gap;
   endtask

   task automatic test_random_phase(input int phase, input int target);
      logic [crsc_pkg::WORD_W-1:0] vals [8];
      int sent;
      int msg_len;
      wait_idle();
      for (int i = 0; i < 8; i++)
         vals[i] = (phase == 0) ? '0 : (phase == 1) ? '1 : {$urandom, $urandom};
      load_registers(vals);
      if (phase == 0) begin
         gap_max   = 0;
         stall_max = 0;
      end else begin
         gap_max   = $urandom_range(10, 0);
         burst_max = $urandom_range(16, 1);
         ready_max = $urandom_range(16, 1);
         stall_max = $urandom_range(12, 0);
      end
      sent = 0;
      while (sent < target) begin
         if ($urandom_range(9, 0) != 0) begin
            send_transfer(crsc_pkg::OP_START, crsc_pkg::INDEX_W'($urandom), rand_word());
            sent++;
         end
         msg_len = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 0) : $urandom_range(12, 1);
         for (int i = 0; i < msg_len; i++) begin
            case ($urandom_range(39, 0))
               0, 1: begin
                  send_transfer(crsc_pkg::OP_LOAD, crsc_pkg::INDEX_W'($urandom), rand_word());
                  sent++;
               end
               2:       send_transfer(OP_UNUSED, crsc_pkg::INDEX_W'($urandom), rand_word());
               default: ;
            endcase
            send_transfer(crsc_pkg::OP_DATA, crsc_pkg::INDEX_W'($urandom), rand_word());
            sent++;
         end
      end
   endtask

   initial begin : rsp_side
      int run_left;
      int hold_left;
      logic ready_phase;
      run_left    = 0;
      hold_left   = 0;
      ready_phase = 1'b0;
      rsp_tready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len  = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            if (run_left == 0) begin
               ready_phase = !ready_phase;
               run_left = ready_phase ? $urandom_range(ready_max, 1)
                                      : $urandom_range(stall_max, 0);
               if (run_left == 0) begin
                  ready_phase = 1'b1;
                  run_left = $urandom_range(ready_max, 1);
               end
            end
            rsp_tready <= ready_phase;
            run_left--;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      cipher_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_words.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[crsc_pkg::WORD_W-1:0], '0);
         end else begin
            want = pending_words.pop_front();
            if (rsp_tdata[crsc_pkg::WORD_W-1:0] !== want.text)
               report_mismatch("text_word", rsp_tdata[crsc_pkg::WORD_W-1:0], want.text);
            if (rsp_tdata[crsc_pkg::WORD_W+crsc_pkg::POS_W-1:crsc_pkg::WORD_W] !== want.pos)
               report_mismatch("word_position",
                  crsc_pkg::WORD_W'(
                     rsp_tdata[crsc_pkg::WORD_W+crsc_pkg::POS_W-1:crsc_pkg::WORD_W]),
                  crsc_pkg::WORD_W'(want.pos));
            n_checked++;
         end
      end
   end

   initial begin : main_seq
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      for (int i = 0; i < crsc_pkg::LANES; i++) begin
         key_csr[i]   = '0;
         nonce_csr[i] = '0;
         ks_state[i]  = '0;
         ks_key[i]    = '0;
      end
      for (int i = 0; i < crsc_pkg::CONSTANT_DEPTH; i++) const_table[i] = '0;
      word_pos = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_table_fill();
      test_data_before_start();
      test_start_and_wrap();
      test_csr_after_start();
      test_restart_mid_block();
      test_unused_opcode();
      test_table_reload();
      test_backpressure();
      for (int p = 0; p < 6; p++) test_random_phase(p, 270);
      wait_idle();

      $display("ran %0d data words, %0d starts, %0d table loads, %0d ignored transfers",
               n_words, n_starts, n_loads, n_ignored);
      $display("checked %0d results over %0d register settings, %0d mismatches",
               n_checked, n_settings, mismatches);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
